// File: rtl/modular_exponentiation_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define MEXP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define MEXP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
// Shared widths, constants and controller/datapath interface types.
package mexp_pkg;

  localparam int MOD_W  = 31;
  localparam int OPND_W = 63;
  localparam int CNT_W  = 6;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Steps of the shared multiplier: one multiplier bit per cycle.
  localparam logic [CNT_W-1:0] RED_STEPS = CNT_W'(OPND_W);
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MOD_W);

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL_ACC,
    OP_SQUARE
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    op_t  op;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
  } sts_t;

endpackage

// File: rtl/mexp_mulmod.sv
// Bit-serial modular multiplier: r = a * x mod m, one bit of x per cycle, MSB first.
module mexp_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mexp_pkg::MOD_W-1:0]  m,
  input  logic [mexp_pkg::MOD_W-1:0]  a,
  input  logic [mexp_pkg::OPND_W-1:0] x_in,
  input  logic [mexp_pkg::CNT_W-1:0]  steps,
  output logic [mexp_pkg::MOD_W-1:0]  r,
  output logic                        done
);
  import mexp_pkg::*;

  logic                 active;
  logic [OPND_W-1:0]    x;
  logic [CNT_W-1:0]     cnt;
  logic [MOD_W:0]       dbl;
  logic [MOD_W:0]       dbl_red;
  logic [MOD_W:0]       sum;
  logic [MOD_W:0]       r_next;

  // Horner step: double the remainder, reduce, add the addend if the bit is set, reduce.
  // Both sums stay below twice the modulus, so one subtraction each suffices.
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (x[OPND_W-1] ? {1'b0, a} : '0);
    r_next  = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        r      <= '0;
        x      <= x_in;
        cnt    <= steps;
      end else if (active) begin
        r   <= r_next[MOD_W-1:0];
        x   <= {x[OPND_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/mexp_dp.sv
// Datapath: modulus register, operand registers and the shared modular multiplier.
module mexp_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mexp_pkg::cmd_t              cmd,
  output mexp_pkg::sts_t              sts,
  input  logic [mexp_pkg::OPND_W-1:0] base_value,
  input  logic [mexp_pkg::OPND_W-1:0] exponent,
  input  logic                        cfg_we,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data,
  output logic [mexp_pkg::MOD_W-1:0]  power_result
);
  import mexp_pkg::*;

  logic [MOD_W-1:0]  modulus;
  logic [MOD_W-1:0]  m_eff;
  logic [OPND_W-1:0] base_reg;
  logic [OPND_W-1:0] expo;
  logic [MOD_W-1:0]  acc;
  logic [MOD_W-1:0]  sq;
  logic [MOD_W-1:0]  mul_a;
  logic [OPND_W-1:0] mul_x;
  logic [CNT_W-1:0]  mul_steps;
  logic [MOD_W-1:0]  mul_r;
  logic              mul_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // A zero modulus behaves as a modulus of one.
  assign m_eff = (modulus == '0) ? MOD_W'(1) : modulus;

  always_comb begin
    case (cmd.op)
      OP_REDUCE: begin
        mul_a     = MOD_W'(1);
        mul_x     = base_reg;
        mul_steps = RED_STEPS;
      end
      OP_MUL_ACC: begin
        mul_a     = sq;
        mul_x     = {acc, {(OPND_W-MOD_W){1'b0}}};
        mul_steps = MUL_STEPS;
      end
      default: begin
        mul_a     = sq;
        mul_x     = {sq, {(OPND_W-MOD_W){1'b0}}};
        mul_steps = MUL_STEPS;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .go    (cmd.mul_go),
    .m     (m_eff),
    .a     (mul_a),
    .x_in  (mul_x),
    .steps (mul_steps),
    .r     (mul_r),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_reg <= base_value;
      expo     <= exponent;
      acc      <= MOD_W'(1);
    end else begin
      if (cmd.shift) begin
        expo <= expo >> 1;
      end
      if (mul_done) begin
        case (cmd.op)
          OP_MUL_ACC: acc <= mul_r;
          default:    sq  <= mul_r;
        endcase
      end
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.exp_zero  = (expo == '0);
  assign sts.exp_lsb   = expo[0];
  assign power_result  = acc;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences base reduction and the square-and-multiply loop.
`include "modular_exponentiation_defines.svh"

module mexp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mexp_pkg::sts_t sts,
  output mexp_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_CHECK,
    S_MACC,
    S_MSQ,
    S_SHIFT
  } state_t;

  state_t state;
  logic   mul_go;
  op_t    op;
  logic   shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mul_go <= 1'b0;
      op     <= OP_REDUCE;
      shift  <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      shift  <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mul_go <= 1'b1;
            op     <= OP_REDUCE;
            state  <= S_RED;
          end
        end
        S_RED: begin
          if (sts.mul_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.exp_zero) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (sts.exp_lsb) begin
            mul_go <= 1'b1;
            op     <= OP_MUL_ACC;
            state  <= S_MACC;
          end else begin
            mul_go <= 1'b1;
            op     <= OP_SQUARE;
            state  <= S_MSQ;
          end
        end
        S_MACC: begin
          if (sts.mul_done) begin
            mul_go <= 1'b1;
            op     <= OP_SQUARE;
            state  <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (sts.mul_done) begin
            shift <= 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          state <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.load   = start && (state == S_IDLE);
  assign cmd.mul_go = mul_go;
  assign cmd.op     = op;
  assign cmd.shift  = shift;

  `MEXP_ASSERT(a_done_idle, done |-> (state == S_IDLE), "result strobe outside idle")
  `MEXP_ASSERT(a_go_wait, mul_go |-> (state == S_RED || state == S_MACC || state == S_MSQ), "multiply started outside a wait state")
  `MEXP_ASSERT_NEXT(a_accept, start && (state == S_IDLE), state == S_RED && mul_go, "accepted word did not start reduction")

endmodule

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
//
//   Channel   Signals                          Handshake
//   -------   ------------------------------   --------------------------------
//   input     start, base_value, exponent      word taken when start && !busy
//   result    done, power_result               one-cycle strobe, cannot stall
//   config    cfg_valid, cfg_ready, cfg_data   write when cfg_valid && cfg_ready
//
// One word is worked on at a time. The base is first reduced modulo the
// modulus on the shared bit-serial multiplier. Each exponent bit then costs
// one modular squaring, preceded by a multiplication into the accumulator
// when the bit is set, plus the loop control states S_SHIFT and S_CHECK.
// The single modular multiplier, retiring one multiplier bit per cycle,
// sets the run time. Reset is synchronous and loads the modulus 1000000007.
// The result strobe cannot be held off; power_result holds its value until
// the next word is accepted.
module modular_exponentiation (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mexp_pkg::OPND_W-1:0] base_value,
  input  logic [mexp_pkg::OPND_W-1:0] exponent,
  output logic                        done,
  output logic [mexp_pkg::MOD_W-1:0]  power_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data
);
  import mexp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The modulus is only written between words.
  assign cfg_ready = !busy;

  mexp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mexp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .base_value   (base_value),
    .exponent     (exponent),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .power_result (power_result)
  );

endmodule
